@@ rtl/periodic_pair_distance_coulomb_core_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef PERIODIC_PAIR_DISTANCE_COULOMB_CORE_ASSERT_SVH
`define PERIODIC_PAIR_DISTANCE_COULOMB_CORE_ASSERT_SVH

// Same-cycle implication.
`define PPDC_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("ppdc check failed");

// Next-cycle implication.
`define PPDC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("ppdc check failed");

`endif

@@ rtl/ppdc_pkg.sv @@
package ppdc_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ID_W       = 16;
    localparam int BOX_W      = 31;
    localparam int SCALE_W    = 32;
    localparam int DIST_W     = COORD_W + 1;
    localparam int ENERGY_W   = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;

    // signed delta, wide enough for both folds
    localparam int DELTA_W    = COORD_W + 3;
    // divider cell remainder / divisor width
    localparam int DIV_W      = DIST_W;
    // |2*delta| dividend for a fold
    localparam int FOLD_DVD_W = COORD_W + 2;
    localparam int MAG_W      = COORD_W + 1;
    localparam int HALF_LO    = (MAG_W + 1) / 2;
    localparam int HALF_HI    = MAG_W - HALF_LO;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int SREM_W     = ROOT_W + 1;
    localparam int QDVD_W     = SCALE_W + FRAC_BITS;

    localparam int AXIS_LAT   = 1 + 2 * (FOLD_DVD_W + 2) + 1;
    localparam int TOTAL_LAT  = AXIS_LAT + 3 + ROOT_W + 1 + QDVD_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;

    localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic valid;
        logic self_pair;
    } tag_t;

    typedef struct packed {
        logic             enable;
        logic [BOX_W-1:0] size;
    } fold_cfg_t;

endpackage

@@ rtl/ppdc_div_cell.sv @@
module ppdc_div_cell
    import ppdc_pkg::*;
(
    input  logic [DIV_W-1:0] rem_in,
    input  logic             bit_in,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] rem_out,
    output logic             q_bit
);

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;

    assign trial   = {rem_in, bit_in};
    assign diff    = trial - {1'b0, divisor};
    assign q_bit   = (trial >= {1'b0, divisor});
    assign rem_out = q_bit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

endmodule

@@ rtl/ppdc_sqrt_cell.sv @@
module ppdc_sqrt_cell
    import ppdc_pkg::*;
(
    input  logic [SREM_W-1:0] rem_in,
    input  logic [ROOT_W-1:0] root_in,
    input  logic [1:0]        pair_in,
    output logic [SREM_W-1:0] rem_out,
    output logic [ROOT_W-1:0] root_out
);

    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] test;
    logic [SREM_W+1:0] diff;
    logic              ge;

    assign trial    = {rem_in, pair_in};
    assign test     = {1'b0, root_in, 2'b01};
    assign diff     = trial - test;
    assign ge       = (trial >= test);
    assign rem_out  = ge ? diff[SREM_W-1:0] : trial[SREM_W-1:0];
    assign root_out = {root_in[ROOT_W-2:0], ge};

endmodule

@@ rtl/ppdc_axis.sv @@
module ppdc_axis
    import ppdc_pkg::*;
(
    input  logic                      clk,
    input  fold_cfg_t                 fold_cfg,
    input  logic signed [COORD_W-1:0] first_pos,
    input  logic signed [COORD_W-1:0] second_pos,
    output logic        [MAG_W-1:0]   mag
);

    logic signed [DELTA_W-1:0]    delta_reg;
    logic signed [DELTA_W-1:0]    d_reg    [2][FOLD_DVD_W+1];
    logic                         neg_reg  [2][FOLD_DVD_W+1];
    logic        [FOLD_DVD_W-1:0] dvd_reg  [2][FOLD_DVD_W+1];
    logic        [DIV_W-1:0]      rem_reg  [2][FOLD_DVD_W+1];
    logic signed [DELTA_W-1:0]    fold_reg [2];
    logic        [MAG_W-1:0]      mag_reg;
    logic signed [DELTA_W-1:0]    last_neg;
    logic        [DIV_W-1:0]      divisor;

    assign divisor  = DIV_W'(fold_cfg.size);
    assign last_neg = -fold_reg[1];
    assign mag      = mag_reg;

    always_ff @(posedge clk)
    begin
        delta_reg <= DELTA_W'(second_pos) - DELTA_W'(first_pos);
        mag_reg   <= fold_reg[1][DELTA_W-1] ? last_neg[MAG_W-1:0] : fold_reg[1][MAG_W-1:0];
    end

    for (genvar f = 0; f < 2; f++)
    begin : g_fold
        logic signed [DELTA_W-1:0] src;
        logic signed [DELTA_W:0]   twice;
        logic signed [DELTA_W:0]   twice_abs;
        logic signed [DELTA_W-1:0] rem_ext;
        logic signed [DELTA_W-1:0] rem_signed;
        logic        [DIV_W-1:0]   rem_last;

        if (f == 0)
        begin : g_src_first
            assign src = delta_reg;
        end
        else
        begin : g_src_next
            assign src = fold_reg[0];
        end

        assign twice     = {src, 1'b0};
        assign twice_abs = src[DELTA_W-1] ? -twice : twice;

        always_ff @(posedge clk)
        begin
            d_reg[f][0]   <= src;
            neg_reg[f][0] <= src[DELTA_W-1];
            dvd_reg[f][0] <= twice_abs[FOLD_DVD_W-1:0];
            rem_reg[f][0] <= '0;
        end

        for (genvar i = 1; i <= FOLD_DVD_W; i++)
        begin : g_cell
            logic [DIV_W-1:0] rem_out;
            logic             q_bit;

            ppdc_div_cell u_cell (
                .rem_in  (rem_reg[f][i-1]),
                .bit_in  (dvd_reg[f][i-1][FOLD_DVD_W-1]),
                .divisor (divisor),
                .rem_out (rem_out),
                .q_bit   (q_bit)
            );

            always_ff @(posedge clk)
            begin
                rem_reg[f][i] <= rem_out;
                dvd_reg[f][i] <= {dvd_reg[f][i-1][FOLD_DVD_W-2:0], q_bit};
                d_reg[f][i]   <= d_reg[f][i-1];
                neg_reg[f][i] <= neg_reg[f][i-1];
            end
        end

        assign rem_last   = rem_reg[f][FOLD_DVD_W];
        assign rem_ext    = DELTA_W'(rem_last);
        assign rem_signed = neg_reg[f][FOLD_DVD_W] ? -rem_ext : rem_ext;

        // d - k*s, with k*s = 2d - rem
        always_ff @(posedge clk)
        begin
            fold_reg[f] <= fold_cfg.enable ? (rem_signed - d_reg[f][FOLD_DVD_W])
                                           : d_reg[f][FOLD_DVD_W];
        end
    end

endmodule

@@ rtl/periodic_pair_distance_coulomb_core.sv @@
// Minimum image pair distance and Coulomb energy, one site pair per clock.
// A pair is taken when start is high and busy is low; busy is high only in
// the first cycle after reset. Each pair yields one word on distance,
// energy and saturated, marked by a one-cycle done strobe. The receiver
// cannot stall the block, so done words must be captured when they appear.
// The datapath holds three rows of one-bit-per-cell stages: two 34-cell
// fold dividers per axis, a 34-cell square root row and a 48-cell energy
// divider row.
// Configuration writes must only occur while no pair is in flight.
module periodic_pair_distance_coulomb_core
    import ppdc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic [ID_W-1:0]           first_id,
    input  logic [ID_W-1:0]           second_id,
    input  logic signed [COORD_W-1:0] first_x,
    input  logic signed [COORD_W-1:0] first_y,
    input  logic signed [COORD_W-1:0] first_z,
    input  logic signed [COORD_W-1:0] second_x,
    input  logic signed [COORD_W-1:0] second_y,
    input  logic signed [COORD_W-1:0] second_z,
    output logic                      done,
    output logic [DIST_W-1:0]         distance,
    output logic [ENERGY_W-1:0]       energy,
    output logic                      saturated
);

    logic                busy_reg;
    logic                accept;
    logic                periodic_reg;
    logic [BOX_W-1:0]    box_x_reg;
    logic [BOX_W-1:0]    box_y_reg;
    logic [BOX_W-1:0]    box_z_reg;
    logic [SCALE_W-1:0]  scale_reg;
    fold_cfg_t           fold_cfg [3];
    logic [MAG_W-1:0]    mag      [3];

    logic [2*HALF_HI-1:0]       pp_hh_reg [3];
    logic [HALF_HI+HALF_LO-1:0] pp_hl_reg [3];
    logic [2*HALF_LO-1:0]       pp_ll_reg [3];
    logic [SQ_W-1:0]            sq_reg    [3];
    logic [SUM_W-1:0]           sum_reg;

    logic [SREM_W-1:0]   srem_reg [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [SUM_W-1:0]    rad_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_final;
    logic [DIST_W-1:0]   dist_reg;

    logic [DIV_W-1:0]    erem_reg [QDVD_W];
    logic [QDVD_W-1:0]   edvd_reg [QDVD_W];
    logic [DIV_W-1:0]    ediv_reg [QDVD_W];
    logic [QDVD_W-1:0]   quot_reg [QDVD_W];
    logic [QDVD_W-1:0]   quot_last;
    logic [DIV_W-1:0]    div_last;

    tag_t                tag_reg [TOTAL_LAT];
    logic [DIST_W-1:0]   dist_out_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic                sat_reg;
    logic [ENERGY_W-1:0] energy_next;
    logic                sat_next;

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            periodic_reg <= 1'b0;
            box_x_reg    <= BOX_RESET;
            box_y_reg    <= BOX_RESET;
            box_z_reg    <= BOX_RESET;
            scale_reg    <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PERIODIC: periodic_reg <= cfg_data[0];
                    REG_BOX_X:    box_x_reg    <= cfg_data[BOX_W-1:0];
                    REG_BOX_Y:    box_y_reg    <= cfg_data[BOX_W-1:0];
                    REG_BOX_Z:    box_z_reg    <= cfg_data[BOX_W-1:0];
                    REG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // folding is skipped on an axis with zero box length
    assign fold_cfg[0] = fold_cfg_t'{periodic_reg && (box_x_reg != '0), box_x_reg};
    assign fold_cfg[1] = fold_cfg_t'{periodic_reg && (box_y_reg != '0), box_y_reg};
    assign fold_cfg[2] = fold_cfg_t'{periodic_reg && (box_z_reg != '0), box_z_reg};

    ppdc_axis u_axis_x (
        .clk        (clk),
        .fold_cfg   (fold_cfg[0]),
        .first_pos  (first_x),
        .second_pos (second_x),
        .mag        (mag[0])
    );

    ppdc_axis u_axis_y (
        .clk        (clk),
        .fold_cfg   (fold_cfg[1]),
        .first_pos  (first_y),
        .second_pos (second_y),
        .mag        (mag[1])
    );

    ppdc_axis u_axis_z (
        .clk        (clk),
        .fold_cfg   (fold_cfg[2]),
        .first_pos  (first_z),
        .second_pos (second_z),
        .mag        (mag[2])
    );

    // squares from half-width partial products
    for (genvar a = 0; a < 3; a++)
    begin : g_square
        logic [HALF_HI-1:0] hi;
        logic [HALF_LO-1:0] lo;

        assign hi = mag[a][MAG_W-1:HALF_LO];
        assign lo = mag[a][HALF_LO-1:0];

        always_ff @(posedge clk)
        begin
            pp_hh_reg[a] <= (2*HALF_HI)'(hi) * (2*HALF_HI)'(hi);
            pp_hl_reg[a] <= (HALF_HI+HALF_LO)'(hi) * (HALF_HI+HALF_LO)'(lo);
            pp_ll_reg[a] <= (2*HALF_LO)'(lo) * (2*HALF_LO)'(lo);
            sq_reg[a]    <= (SQ_W'(pp_hh_reg[a]) << (2*HALF_LO))
                          + (SQ_W'(pp_hl_reg[a]) << (HALF_LO+1))
                          + SQ_W'(pp_ll_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    // square root row, two radicand bits per cell
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        logic [SREM_W-1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  rad_in;
        logic [SREM_W-1:0] rem_out;
        logic [ROOT_W-1:0] root_out;

        if (i == 0)
        begin : g_head
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = sum_reg;
        end
        else
        begin : g_body
            assign rem_in  = srem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
        end

        ppdc_sqrt_cell u_cell (
            .rem_in   (rem_in),
            .root_in  (root_in),
            .pair_in  (rad_in[SUM_W-1:SUM_W-2]),
            .rem_out  (rem_out),
            .root_out (root_out)
        );

        always_ff @(posedge clk)
        begin
            srem_reg[i] <= rem_out;
            root_reg[i] <= root_out;
            rad_reg[i]  <= {rad_in[SUM_W-3:0], 2'b00};
        end
    end

    assign root_final = root_reg[ROOT_W-1];

    always_ff @(posedge clk)
    begin
        dist_reg <= root_final[ROOT_W-1] ? '1 : root_final[DIST_W-1:0];
    end

    // energy divider row: (scale << FRAC_BITS) / distance
    for (genvar i = 0; i < QDVD_W; i++)
    begin : g_energy
        logic [DIV_W-1:0]  rem_in;
        logic [QDVD_W-1:0] dvd_in;
        logic [DIV_W-1:0]  div_in;
        logic [QDVD_W-1:0] quot_in;
        logic [DIV_W-1:0]  rem_out;
        logic              q_bit;

        if (i == 0)
        begin : g_head
            assign rem_in  = '0;
            assign dvd_in  = {scale_reg, {FRAC_BITS{1'b0}}};
            assign div_in  = dist_reg;
            assign quot_in = '0;
        end
        else
        begin : g_body
            assign rem_in  = erem_reg[i-1];
            assign dvd_in  = edvd_reg[i-1];
            assign div_in  = ediv_reg[i-1];
            assign quot_in = quot_reg[i-1];
        end

        ppdc_div_cell u_cell (
            .rem_in  (rem_in),
            .bit_in  (dvd_in[QDVD_W-1]),
            .divisor (div_in),
            .rem_out (rem_out),
            .q_bit   (q_bit)
        );

        always_ff @(posedge clk)
        begin
            erem_reg[i] <= rem_out;
            edvd_reg[i] <= {dvd_in[QDVD_W-2:0], 1'b0};
            ediv_reg[i] <= div_in;
            quot_reg[i] <= {quot_in[QDVD_W-2:0], q_bit};
        end
    end

    assign quot_last = quot_reg[QDVD_W-1];
    assign div_last  = ediv_reg[QDVD_W-1];

    always_comb
    begin
        energy_next = '0;
        sat_next    = 1'b0;
        if (!tag_reg[TOTAL_LAT-2].self_pair)
        begin
            if ((div_last == '0) || (quot_last[QDVD_W-1:ENERGY_W] != '0))
            begin
                energy_next = '1;
                sat_next    = 1'b1;
            end
            else
            begin
                energy_next = quot_last[ENERGY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dist_out_reg <= div_last;
        energy_reg   <= energy_next;
        sat_reg      <= sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_LAT; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_t'{accept, (first_id == second_id)};
            for (int i = 1; i < TOTAL_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign done      = tag_reg[TOTAL_LAT-1].valid;
    assign distance  = dist_out_reg;
    assign energy    = energy_reg;
    assign saturated = sat_reg;

endmodule

@@ rtl/ppdc_checker.sv @@
`include "periodic_pair_distance_coulomb_core_assert.svh"

module ppdc_checker
    import ppdc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      cfg_we,
    input logic [CFG_IDX_W-1:0]      cfg_index,
    input logic [CFG_W-1:0]          cfg_data,
    input logic [ID_W-1:0]           first_id,
    input logic [ID_W-1:0]           second_id,
    input logic signed [COORD_W-1:0] first_x,
    input logic signed [COORD_W-1:0] first_y,
    input logic signed [COORD_W-1:0] first_z,
    input logic signed [COORD_W-1:0] second_x,
    input logic signed [COORD_W-1:0] second_y,
    input logic signed [COORD_W-1:0] second_z,
    input logic                      done,
    input logic [DIST_W-1:0]         distance,
    input logic [ENERGY_W-1:0]       energy,
    input logic                      saturated
);

    logic accept;

    assign accept = start && !busy;

    // once out of reset the block never turns busy again
    `PPDC_ASSERT_NEXT(a_busy_stays_low, clk, rst_n, !busy, !busy)

    // every word comes from a pair that was taken earlier
    `PPDC_ASSERT_IMPLY(a_done_after_accept, clk, rst_n, done, $past(accept, TOTAL_LAT))

    `PPDC_ASSERT_IMPLY(a_sat_means_max, clk, rst_n, done && saturated, energy == '1)

    // zero distance: self pair gives zero energy, otherwise clamped
    `PPDC_ASSERT_IMPLY(a_zero_distance, clk, rst_n, done && (distance == '0), (energy == '0 && !saturated) || (energy == '1 && saturated))

endmodule

bind periodic_pair_distance_coulomb_core ppdc_checker u_ppdc_checker (.*);
